>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helper macros
// wraps concurrent assertions so they drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

>>> design/mpts_pkg.sv
// ----------------------------------------------------------------------------
// mpts_pkg
// shared types and constants of the memory probe test sequencer
// ----------------------------------------------------------------------------
package mpts_pkg;

  // test patterns and limits
  localparam logic [31:0] PAT_A     = 32'haa55aa55;
  localparam logic [31:0] PAT_B     = 32'h55aa55aa;
  localparam logic [31:0] MIN_START = 32'h0010_0000;
  localparam logic [31:0] MIN_GRAIN = 32'h0000_0400;

  // register reset values
  localparam logic [31:0] START_RESET    = 32'h0010_0000;
  localparam logic [31:0] GRAIN_RESET    = 32'h0000_1000;
  localparam logic [31:0] RESERVED_RESET = 32'h0000_0000;

  // register indexes
  localparam logic [1:0] REG_START    = 2'd0;
  localparam logic [1:0] REG_GRAIN    = 2'd1;
  localparam logic [1:0] REG_RESERVED = 2'd2;

  // input action codes
  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  // result kinds
  localparam logic [2:0] K_READ  = 3'd0;
  localparam logic [2:0] K_WRITE = 3'd1;
  localparam logic [2:0] K_DONE  = 3'd2;
  localparam logic [2:0] K_LOW   = 3'd3;
  localparam logic [2:0] K_SMALL = 3'd4;

  typedef struct packed {
    logic [31:0] start_address;
    logic [31:0] grain_size;
    logic [31:0] reserved_end;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] usable_start;
    logic [31:0] usable_size;
  } res_t;

endpackage

>>> design/mpts_cfg.sv
// ----------------------------------------------------------------------------
// mpts_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module mpts_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output mpts_pkg::cfg_t    cfg
);
  import mpts_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_address <= START_RESET;
      cfg.grain_size    <= GRAIN_RESET;
      cfg.reserved_end  <= RESERVED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:    cfg.start_address <= cfg_data;
        REG_GRAIN:    cfg.grain_size    <= cfg_data;
        REG_RESERVED: cfg.reserved_end  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/mpts_core.sv
// ----------------------------------------------------------------------------
// mpts_core
// probe sequencer state and the next-command logic for one item
// ----------------------------------------------------------------------------
module mpts_core #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           action,
  input  logic [31:0]    read_data,
  input  mpts_pkg::cfg_t cfg,
  output logic           res_valid,
  output mpts_pkg::res_t res
);
  import mpts_pkg::*;

  // phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SAVE    = 3'd1;
  localparam logic [2:0] PH_WRITE_A = 3'd2;
  localparam logic [2:0] PH_CHECK_A = 3'd3;
  localparam logic [2:0] PH_WRITE_B = 3'd4;
  localparam logic [2:0] PH_CHECK_B = 3'd5;
  localparam logic [2:0] PH_RESTORE = 3'd6;

  // top of the tested space, capped at 4 GiB
  localparam int          TOP_SHIFT = (ADDR_WIDTH > 32) ? 32 : ADDR_WIDTH;
  localparam logic [33:0] SPACE_TOP = 34'd1 << TOP_SHIFT;

  logic [2:0]  phase, phase_next;
  logic [31:0] probe_address, probe_address_next;
  logic [31:0] saved_word, saved_word_next;
  logic        check_failed, check_failed_next;
  logic        second_probe, second_probe_next;
  logic [31:0] good_grains, good_grains_next;

  logic [33:0] start_end;
  logic [33:0] next_end;
  logic        start_fits;
  logic        next_fits;
  logic [31:0] grains_plus;
  logic [31:0] last_word;
  logic [31:0] next_base;
  logic [31:0] fin_count;
  logic [31:0] fin_size_in;
  logic [31:0] fin_diff;
  logic [31:0] fin_size;
  logic [31:0] fin_start;

  // grain fit checks against the top of the space
  assign start_end  = {2'b00, cfg.start_address} + {2'b00, cfg.grain_size};
  assign next_end   = {2'b00, probe_address} + 34'd4 + {2'b00, cfg.grain_size};
  assign start_fits = (cfg.grain_size != '0) && (start_end <= SPACE_TOP);
  assign next_fits  = (cfg.grain_size != '0) && (next_end <= SPACE_TOP);

  // grain count and addresses of the next probe
  assign grains_plus = good_grains + 32'd1;
  assign last_word   = probe_address + cfg.grain_size - 32'd4;
  assign next_base   = probe_address + 32'd4;

  // usable region, trimmed against the reserved end
  always_comb begin
    fin_count = '0;
    if (action == ACT_START) begin
      fin_count = '0;
    end else if (check_failed) begin
      fin_count = good_grains;
    end else begin
      fin_count = grains_plus;
    end
    // size uses the grain size in force now, low 32 bits
    fin_size_in = fin_count * cfg.grain_size;
    fin_diff  = cfg.reserved_end - cfg.start_address;
    fin_size  = fin_size_in;
    fin_start = cfg.start_address;
    if (cfg.start_address <= cfg.reserved_end) begin
      fin_size  = (fin_size_in > fin_diff) ? (fin_size_in - fin_diff) : '0;
      fin_start = cfg.reserved_end;
    end
  end

  // next state and result for the current item
  always_comb begin
    phase_next         = phase;
    probe_address_next = probe_address;
    saved_word_next    = saved_word;
    check_failed_next  = check_failed;
    second_probe_next  = second_probe;
    good_grains_next   = good_grains;
    res_valid          = 1'b0;
    res                = '0;

    if (action == ACT_START) begin
      phase_next = PH_IDLE;
      res_valid  = 1'b1;
      if (cfg.start_address < MIN_START) begin
        res.kind = K_LOW;
      end else if (cfg.grain_size < MIN_GRAIN) begin
        res.kind = K_SMALL;
      end else begin
        good_grains_next  = '0;
        check_failed_next = 1'b0;
        second_probe_next = 1'b0;
        saved_word_next   = '0;
        if (!start_fits) begin
          res.kind         = K_DONE;
          res.usable_start = fin_start;
          res.usable_size  = fin_size;
        end else begin
          probe_address_next = cfg.start_address;
          phase_next         = PH_SAVE;
          res.kind           = K_READ;
          res.address        = cfg.start_address;
        end
      end
    end else begin
      unique case (phase)
        PH_SAVE: begin
          saved_word_next = read_data;
          phase_next      = PH_WRITE_A;
          res_valid       = 1'b1;
          res.kind        = K_WRITE;
          res.address     = probe_address;
          res.write_data  = PAT_A;
        end
        PH_WRITE_A: begin
          phase_next  = PH_CHECK_A;
          res_valid   = 1'b1;
          res.kind    = K_READ;
          res.address = probe_address;
        end
        PH_CHECK_A: begin
          if (read_data != PAT_A) check_failed_next = 1'b1;
          phase_next     = PH_WRITE_B;
          res_valid      = 1'b1;
          res.kind       = K_WRITE;
          res.address    = probe_address;
          res.write_data = PAT_B;
        end
        PH_WRITE_B: begin
          phase_next  = PH_CHECK_B;
          res_valid   = 1'b1;
          res.kind    = K_READ;
          res.address = probe_address;
        end
        PH_CHECK_B: begin
          if (read_data != PAT_B) check_failed_next = 1'b1;
          phase_next     = PH_RESTORE;
          res_valid      = 1'b1;
          res.kind       = K_WRITE;
          res.address    = probe_address;
          res.write_data = saved_word;
        end
        PH_RESTORE: begin
          res_valid = 1'b1;
          if (check_failed) begin
            phase_next       = PH_IDLE;
            res.kind         = K_DONE;
            res.usable_start = fin_start;
            res.usable_size  = fin_size;
          end else if (!second_probe) begin
            // last word of the same grain
            second_probe_next  = 1'b1;
            probe_address_next = last_word;
            phase_next         = PH_SAVE;
            res.kind           = K_READ;
            res.address        = last_word;
          end else begin
            // grain passed, move to the next one
            second_probe_next = 1'b0;
            good_grains_next  = grains_plus;
            if (!next_fits) begin
              phase_next       = PH_IDLE;
              res.kind         = K_DONE;
              res.usable_start = fin_start;
              res.usable_size  = fin_size;
            end else begin
              probe_address_next = next_base;
              phase_next         = PH_SAVE;
              res.kind           = K_READ;
              res.address        = next_base;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      check_failed <= 1'b0;
      second_probe <= 1'b0;
      good_grains  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      check_failed <= check_failed_next;
      second_probe <= second_probe_next;
      good_grains  <= good_grains_next;
    end
  end

  // probe payload
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_address <= '0;
      saved_word    <= '0;
    end else if (step) begin
      probe_address <= probe_address_next;
      saved_word    <= saved_word_next;
    end
  end

endmodule

>>> design/memory_probe_test_sequencer.sv
// ----------------------------------------------------------------------------
// memory_probe_test_sequencer
// Memory test sequencer: a start item checks the configuration and walks
// memory grain by grain, probing the first and last word of each grain with
// save, write/check 0xaa55aa55, write/check 0x55aa55aa and restore. Each
// response item in a walk yields the next read or write command, or a done
// item with the usable region. One item is taken per cycle while the output
// is not stalled; a result passes the input register, then the result
// register. Ready on the input follows whether the result register can move
// on, so an output stall holds the input once the input register is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module memory_probe_test_sequencer #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  // configuration writes
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  // input items
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // read_data[31:0]
  input  logic          s_tuser,   // action[0]
  // result items
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // address, write_data, usable_start, usable_size
  output logic [2:0]    m_tuser    // kind[2:0]
);
  import mpts_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic        in_action;
  logic [31:0] in_read_data;
  logic        advance;
  logic        step;
  logic        res_valid;
  res_t        res;
  res_t        out_res;

  // configuration registers
  mpts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake control
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action    <= s_tuser;
      in_read_data <= s_tdata;
    end
  end

  // sequencer
  mpts_core #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .action    (in_action),
    .read_data (in_read_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {out_res.usable_size, out_res.usable_start,
                    out_res.write_data, out_res.address};

  // checks
  `ASSERT_NEVER(a_kind_code, clk, rst, m_tvalid && (m_tuser > K_SMALL))
  `ASSERT_PROP(a_read_no_data, clk, rst,
    (m_tvalid && (m_tuser == K_READ)) |-> (m_tdata[127:32] == '0))
  `ASSERT_PROP(a_done_no_cmd, clk, rst,
    (m_tvalid && (m_tuser == K_DONE)) |-> (m_tdata[63:0] == '0))
  `ASSERT_PROP(a_accept_loads, clk, rst,
    (s_tvalid && s_tready) |=> in_valid)

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the memory probe test sequencer. The bench plays
// the memory side: it answers each read or write command with a response
// item, usually with the data a healthy memory would return and now and then
// with a corrupted pattern. A built-in model of the grain walk predicts every
// command and done report, and a monitor compares the result stream against
// it field by field. Directed cases cover rejected configurations, grains
// past the top of the address space, a full walk, a failed check and a long
// output stall. Random rounds then follow under several input and output
// idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import mpts_pkg::*;

  // walk position of the model
  typedef enum logic [2:0] {
    W_IDLE, W_SAVE, W_WRITE_A, W_CHECK_A, W_WRITE_B, W_CHECK_B, W_RESTORE
  } walk_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = REG_START;
  logic [31:0]  cfg_data = 32'h0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = 32'h0;   // read_data[31:0]
  logic         s_tuser = 1'b0;    // action[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;           // address, write_data, usable_start, usable_size
  logic [2:0]   m_tuser;           // kind[2:0]

  // model copy of the registers and the walk state
  cfg_t         cfg;
  walk_t        walk_phase;
  logic [31:0]  probe_addr;
  logic [31:0]  saved_word;
  logic         check_bad;
  logic         on_last_word;
  logic [31:0]  good_grains;

  res_t         expected_results[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           items_with_result = 0;
  int           kind_seen[5] = '{0, 0, 0, 0, 0};
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;

  memory_probe_test_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model of the grain walk
  // ---------------------------------------------------------------------------

  // a grain counts only if it lies wholly below 4 GiB
  function automatic bit grain_fits(input logic [63:0] base);
    return cfg.grain_size != 32'h0 && base + cfg.grain_size <= 64'h1_0000_0000;
  endfunction

  function automatic res_t done_report();
    res_t        r;
    logic [31:0] size;
    logic [31:0] diff;
    r = '0;
    size = good_grains * cfg.grain_size;
    r.usable_start = cfg.start_address;
    // region overlapping the reserved image gets trimmed
    if (cfg.start_address <= cfg.reserved_end) begin
      diff = cfg.reserved_end - cfg.start_address;
      size = (size > diff) ? size - diff : 32'h0;
      r.usable_start = cfg.reserved_end;
    end
    r.kind = K_DONE;
    r.usable_size = size;
    walk_phase = W_IDLE;
    return r;
  endfunction

  function automatic res_t probe_read(input logic [31:0] addr);
    res_t r;
    r = '0;
    probe_addr = addr;
    walk_phase = W_SAVE;
    r.kind = K_READ;
    r.address = addr;
    return r;
  endfunction

  function automatic res_t probe_cmd(input logic [2:0] kind, input logic [31:0] data,
                                     input walk_t next_phase);
    res_t r;
    r = '0;
    r.kind = kind;
    r.address = probe_addr;
    r.write_data = data;
    walk_phase = next_phase;
    return r;
  endfunction

  // advances the model by one item; returns 1 when a result is due
  function automatic bit sequencer_step(input logic act, input logic [31:0] rd,
                                        output res_t r);
    logic [63:0] next_addr;
    r = '0;
    if (act == ACT_START) begin
      walk_phase = W_IDLE;
      if (cfg.start_address < MIN_START) begin
        r.kind = K_LOW;
        return 1'b1;
      end
      if (cfg.grain_size < MIN_GRAIN) begin
        r.kind = K_SMALL;
        return 1'b1;
      end
      good_grains = 32'h0;
      check_bad = 1'b0;
      on_last_word = 1'b0;
      saved_word = 32'h0;
      r = grain_fits({32'h0, cfg.start_address}) ? probe_read(cfg.start_address)
                                                 : done_report();
      return 1'b1;
    end
    case (walk_phase)
      W_SAVE: begin
        saved_word = rd;
        r = probe_cmd(K_WRITE, PAT_A, W_WRITE_A);
      end
      W_WRITE_A: r = probe_cmd(K_READ, 32'h0, W_CHECK_A);
      W_CHECK_A: begin
        if (rd != PAT_A) check_bad = 1'b1;
        r = probe_cmd(K_WRITE, PAT_B, W_WRITE_B);
      end
      W_WRITE_B: r = probe_cmd(K_READ, 32'h0, W_CHECK_B);
      W_CHECK_B: begin
        if (rd != PAT_B) check_bad = 1'b1;
        r = probe_cmd(K_WRITE, saved_word, W_RESTORE);
      end
      W_RESTORE: begin
        if (check_bad) begin
          r = done_report();
        end else if (!on_last_word) begin
          // same grain, last word
          on_last_word = 1'b1;
          r = probe_read(probe_addr + cfg.grain_size - 32'd4);
        end else begin
          on_last_word = 1'b0;
          good_grains = good_grains + 32'd1;
          next_addr = {32'h0, probe_addr} + 64'd4;
          r = grain_fits(next_addr) ? probe_read(next_addr[31:0]) : done_report();
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // word a memory would return for the pending command
  function automatic logic [31:0] memory_word(input bit corrupt);
    logic [31:0] flip;
    flip = 32'd1 << $urandom_range(0, 31);
    case (walk_phase)
      W_CHECK_A: return corrupt ? (PAT_A ^ flip) : PAT_A;
      W_CHECK_B: return corrupt ? (PAT_B ^ flip) : PAT_B;
      default:   return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic act, input logic [31:0] rd);
    res_t r;
    // random gap before the item
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= rd;
    do @(posedge clk); while (!s_tready);
    if (sequencer_step(act, rd, r)) begin
      expected_results.push_back(r);
      items_with_result++;
    end
    items_sent++;
  endtask

  task automatic send_start();
    send_item(ACT_START, $urandom);
  endtask

  task automatic send_response(input bit corrupt);
    send_item(ACT_RESPONSE, memory_word(corrupt));
  endtask

  // hold the input until every result is out, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_START:    cfg.start_address = value;
      REG_GRAIN:    cfg.grain_size = value;
      REG_RESERVED: cfg.reserved_end = value;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [31:0] start_addr, input logic [31:0] grain,
                              input logic [31:0] reserved);
    wait_idle();
    write_reg(REG_START, start_addr);
    write_reg(REG_GRAIN, grain);
    write_reg(REG_RESERVED, reserved);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.address = m_tdata[31:0];
      got.write_data = m_tdata[63:32];
      got.usable_start = m_tdata[95:64];
      got.usable_size = m_tdata[127:96];
      if (got.kind <= K_SMALL) kind_seen[got.kind]++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, actual kind %0d addr %h",
                 $time, got.kind, got.address);
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("address", want.address, got.address);
        check_field("write_data", want.write_data, got.write_data);
        check_field("usable_start", want.usable_start, got.usable_start);
        check_field("usable_size", want.usable_size, got.usable_size);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // start below 1 MiB wins over a small grain, then small grains alone
  task automatic test_config_errors();
    write_config(32'h0, GRAIN_RESET, RESERVED_RESET);
    send_start();
    write_config(MIN_START - 32'd1, 32'h0, RESERVED_RESET);
    send_start();
    write_config(MIN_START, MIN_GRAIN - 32'd1, RESERVED_RESET);
    send_start();
    write_config(MIN_START, 32'h0, RESERVED_RESET);
    send_start();
  endtask

  // first grain does not fit: done at once with nothing usable
  task automatic test_grain_past_top();
    write_config(32'hFFFF_FFFF, MIN_GRAIN, 32'hFFFF_FFFF);
    send_start();
    write_config(MIN_START, 32'hFFFF_FFFF, RESERVED_RESET);
    send_start();
  endtask

  // one grain right under the top, reserved image cuts into it
  task automatic test_single_grain_walk();
    write_config(32'hFFFF_FC00, MIN_GRAIN, 32'hFFFF_FD00);
    send_start();
    while (walk_phase != W_IDLE) send_response(1'b0);
  endtask

  // stray response, restart while busy, then a failed pattern check
  task automatic test_check_failure();
    write_config(32'hFFFF_F000, 32'h800, RESERVED_RESET);
    send_response(1'b0);
    send_start();
    send_response(1'b0);
    send_response(1'b0);
    send_start();
    send_response(1'b0);
    send_response(1'b0);
    send_response(1'b1);
    while (walk_phase != W_IDLE) send_response(1'b0);
  endtask

  // long output stall while items keep coming
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    write_config(32'hFFF0_0000, MIN_GRAIN, RESERVED_RESET);
    @(negedge clk) hold_left = 300;
    @(posedge clk);
    send_start();
    repeat (60) send_response(1'b0);
    wait_idle();
  endtask

  task automatic run_round();
    logic [31:0] g;
    logic [31:0] s;
    logic [31:0] rsv;
    logic [31:0] extra;
    int          n;
    bit          broken;
    case ($urandom_range(0, 19))
      0: begin
        s = $urandom_range(0, MIN_START - 32'd1);
        g = $urandom;
      end
      1: begin
        s = $urandom_range(MIN_START, 32'hFFFF_FFFF);
        g = $urandom_range(0, MIN_GRAIN - 32'd1);
      end
      2: begin
        s = $urandom_range(MIN_START, 32'hFFFF_FFFF);
        g = $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
      end
      default: begin
        // a few grains right under the top keep walks short
        n = $urandom_range(1, 5);
        case ($urandom_range(0, 9))
          0:       g = MIN_GRAIN;
          1:       g = GRAIN_RESET;
          2:       g = $urandom_range(MIN_GRAIN, 32'h4000);
          default: g = $urandom_range(MIN_GRAIN, 32'h1_0000) & 32'hFFFF_FFFC;
        endcase
        extra = $urandom_range(0, g - 32'd1);
        if ($urandom_range(0, 3) != 0) extra = extra & 32'hFFFF_FFFC;
        s = 32'd0 - n * g - extra;
      end
    endcase
    case ($urandom_range(0, 5))
      0:       rsv = 32'h0;
      1:       rsv = 32'hFFFF_FFFF;
      2:       rsv = s;
      3:       rsv = s + $urandom_range(0, 32'h4_0000);
      4:       rsv = $urandom_range(0, s);
      default: rsv = $urandom;
    endcase
    write_config(s, g, rsv);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 4) == 0) send_response(1'b0);
      send_start();
      broken = 1'b0;
      while (walk_phase != W_IDLE && !broken) begin
        if ($urandom_range(0, 79) == 0) send_start();
        else if ($urandom_range(0, 149) == 0) broken = 1'b1;
        else send_response($urandom_range(0, 59) == 0);
      end
    end
  endtask

  task automatic test_random_walks();
    int idle_set[4] = '{0, 48, 0, 6};
    int stall_set[4] = '{0, 0, 48, 6};
    int phase_end;
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      phase_end = items_with_result + 420;
      while (items_with_result < phase_end) run_round();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg.start_address = START_RESET;
    cfg.grain_size = GRAIN_RESET;
    cfg.reserved_end = RESERVED_RESET;
    walk_phase = W_IDLE;
    probe_addr = 32'h0;
    saved_word = 32'h0;
    check_bad = 1'b0;
    on_last_word = 1'b0;
    good_grains = 32'h0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_config_errors();
    test_grain_past_top();
    test_single_grain_walk();
    test_check_failure();
    test_backpressure();
    test_random_walks();
    wait_idle();
    repeat (4) @(posedge clk);
    $display("covered %0d items (%0d with a result), four idling mixes and a 300 cycle stall",
             items_sent, items_with_result);
    $display("results seen: %0d reads, %0d writes, %0d done, %0d low start, %0d small grain",
             kind_seen[K_READ], kind_seen[K_WRITE], kind_seen[K_DONE], kind_seen[K_LOW],
             kind_seen[K_SMALL]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("memory_probe_test_sequencer test passed");
    end else begin
      $display("memory_probe_test_sequencer test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("memory_probe_test_sequencer test failed");
    $finish;
  end

endmodule

>>> memory_probe_test_sequencer.f
+incdir+design
design/mpts_pkg.sv
design/mpts_cfg.sv
design/mpts_core.sv
design/memory_probe_test_sequencer.sv
bench/tb_top.sv
